// ===== rtl/sdsp_pkg.sv =====
// Shared types and constants for the SD card SPI port.
`default_nettype none
package sdsp_pkg;

  // Bus access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Register map.
  localparam logic [1:0] ADDR_DATA     = 2'd0;
  localparam logic [1:0] ADDR_EXCHANGE = 2'd1;
  localparam logic [1:0] ADDR_SELECT   = 2'd2;
  localparam logic [1:0] ADDR_DESELECT = 2'd3;

  // Command frame layout.
  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned FRAME_IDX_W = $clog2(FRAME_BYTES);

  // Card commands understood by the model.
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_OP    = 6'd1;
  localparam logic [5:0] CMD_STOP_TRAN  = 6'd12;
  localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_MULTI = 6'd18;

  // Byte values seen on the SPI line.
  localparam logic [7:0] BYTE_IDLE      = 8'hff;
  localparam logic [7:0] BYTE_TOKEN     = 8'hfe;
  localparam logic [7:0] R1_IDLE        = 8'h01;
  localparam logic [7:0] R1_READY       = 8'h00;
  localparam logic [1:0] CMD_START_BITS = 2'b01;

  localparam logic [31:0] BLKLEN_RESET = 32'd512;

  // Requests from the bus side to the card.
  typedef struct packed {
    logic exchange;
    logic select;
    logic deselect;
  } card_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sd_card_spi_port_top.sv =====
// Top level of the SD card SPI port: bus register stage, card model and result stage.
//
// This block is a bus-mapped SPI port with a model of an SD card in SPI mode
// behind it. Each bus access is one word on the input channel and gives exactly
// one word on the output channel. A write to address 0 loads the transmit byte,
// a write to address 1 exchanges it with the card (the card's answer becomes the
// receive byte and the transmit byte returns to 0xff), and writes to addresses 2
// and 3 raise and drop chip select. A read of address 0 returns the receive byte;
// every other access returns 0xff. The card answers CMD0, CMD1, CMD12, CMD16 and
// CMD18; during a multi-block read each data byte is taken from the media_byte_i
// field of the word and media_address_o tells the host which byte the next data
// byte will be taken from. An access word is first held in an input register,
// and its result is then registered in an output register, where it stays valid
// until it is taken. The port accepts one word per cycle: the card update is
// a single pass of logic between those two registers, and a waiting result only
// holds up the input stage once both are full.
`default_nettype none
module sd_card_spi_port_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [1:0]  address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  media_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic [31:0]      media_address_o,
  output logic             media_read_o
);

  // Input register holding the accepted access word.
  logic        s1_valid_q;
  logic        cmd_q;
  logic [1:0]  addr_q;
  logic [7:0]  wdata_q;
  logic [7:0]  media_q;

  // Result register.
  logic        out_valid_q;
  logic [7:0]  rdata_q, rdata_d;
  logic [31:0] maddr_q;
  logic        mread_q;

  // Port registers.
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;

  logic        in_fire;
  logic        proc;
  sdsp_pkg::card_ctrl_t card_ctrl;
  logic [7:0]  card_answer;
  logic        card_took;
  logic [31:0] card_rptr_next;

  // The access in the input register moves on whenever the result slot is free
  // or is being emptied in the same cycle.
  assign proc       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || proc;
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode the access into card requests. They only act when the word is processed.
  always_comb begin
    card_ctrl = '0;
    if (proc && (cmd_q == sdsp_pkg::ACC_WRITE)) begin
      unique case (addr_q)
        sdsp_pkg::ADDR_EXCHANGE: card_ctrl.exchange = 1'b1;
        sdsp_pkg::ADDR_SELECT:   card_ctrl.select   = 1'b1;
        sdsp_pkg::ADDR_DESELECT: card_ctrl.deselect = 1'b1;
        default:                 card_ctrl          = '0;
      endcase
    end
  end

  sdsp_card u_card (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (card_ctrl),
    .tx_byte_i     (tx_q),
    .media_byte_i  (media_q),
    .answer_o      (card_answer),
    .took_media_o  (card_took),
    .rd_ptr_next_o (card_rptr_next)
  );

  // Transmit and receive bytes, and the read data of this access.
  always_comb begin
    tx_d    = tx_q;
    rx_d    = rx_q;
    rdata_d = sdsp_pkg::BYTE_IDLE;
    if (proc) begin
      if (cmd_q == sdsp_pkg::ACC_WRITE) begin
        if (addr_q == sdsp_pkg::ADDR_DATA) begin
          tx_d = wdata_q;
        end else if (addr_q == sdsp_pkg::ADDR_EXCHANGE) begin
          rx_d = card_answer;
          tx_d = sdsp_pkg::BYTE_IDLE;
        end
      end else if (addr_q == sdsp_pkg::ADDR_DATA) begin
        rdata_d = rx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tx_q        <= sdsp_pkg::BYTE_IDLE;
      rx_q        <= sdsp_pkg::BYTE_IDLE;
    end else begin
      tx_q <= tx_d;
      rx_q <= rx_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= command_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      media_q <= media_byte_i;
    end
    if (proc) begin
      rdata_q <= rdata_d;
      maddr_q <= card_rptr_next;
      mread_q <= card_took;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign media_address_o = maddr_q;
  assign media_read_o    = mread_q;

  // A processed word always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed word did not reach the result register");

  // An empty input register must always be able to take a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  // Media is only consumed by an exchange.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    card_took |-> card_ctrl.exchange)
    else $error("media consumed without an exchange");

  // Consuming a media byte advances the media address by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && card_took) |=> (media_read_o && (media_address_o == $past(card_rptr_next))))
    else $error("media read not reflected in the result");

  // The transmit byte is back at 0xff after every exchange.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    card_ctrl.exchange |=> (tx_q == sdsp_pkg::BYTE_IDLE))
    else $error("transmit byte not restored after exchange");

endmodule
`default_nettype wire

// ===== rtl/sdsp_card.sv =====
// SD card model in SPI mode: frame collection, command decode and block read.
`default_nettype none
module sdsp_card (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sdsp_pkg::card_ctrl_t ctrl_i,
  input  wire logic [7:0]         tx_byte_i,
  input  wire logic [7:0]         media_byte_i,
  output logic [7:0]              answer_o,
  output logic                    took_media_o,
  output logic [31:0]             rd_ptr_next_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COMMAND,
    PH_RESPONSE,
    PH_READ_RESPONSE,
    PH_READ
  } phase_e;

  localparam int unsigned IW = sdsp_pkg::FRAME_IDX_W;

  phase_e      phase_q, phase_d;
  logic        sel_q, sel_d;
  logic [32:0] cnt_q, cnt_d;
  logic [31:0] blen_q, blen_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] rptr_q, rptr_d;

  logic [7:0]  frame_q [sdsp_pkg::FRAME_BYTES];
  logic        frame_we;
  logic [IW-1:0] frame_idx;

  logic [5:0]  cmd;
  logic [31:0] arg;
  logic        is_cmd_byte;
  logic [33:0] len_plus2;

  assign cmd         = frame_q[0][5:0];
  assign arg         = {frame_q[1], frame_q[2], frame_q[3], frame_q[4]};
  assign is_cmd_byte = (tx_byte_i[7:6] == sdsp_pkg::CMD_START_BITS);
  assign len_plus2   = {2'b00, blen_q} + 34'd2;

  always_comb begin
    phase_d      = phase_q;
    sel_d        = sel_q;
    cnt_d        = cnt_q;
    blen_d       = blen_q;
    pend_d       = pend_q;
    rptr_d       = rptr_q;
    answer_o     = sdsp_pkg::BYTE_IDLE;
    took_media_o = 1'b0;
    frame_we     = 1'b0;
    frame_idx    = '0;

    if (ctrl_i.select) begin
      if (!sel_q) begin
        phase_d = PH_IDLE;
      end
      sel_d = 1'b1;
    end else if (ctrl_i.deselect) begin
      sel_d = 1'b0;
    end else if (ctrl_i.exchange && sel_q) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (is_cmd_byte) begin
            phase_d  = PH_COMMAND;
            frame_we = 1'b1;
            cnt_d    = 33'd1;
          end
        end
        PH_COMMAND: begin
          frame_idx = cnt_q[IW-1:0];
          frame_we  = (cnt_q < 33'(sdsp_pkg::FRAME_BYTES));
          cnt_d     = cnt_q + 33'd1;
          // The last frame byte completes the frame; entries before it are stored.
          if (cnt_q == 33'(sdsp_pkg::FRAME_BYTES - 1)) begin
            unique case (cmd)
              sdsp_pkg::CMD_GO_IDLE: begin
                pend_d  = sdsp_pkg::R1_IDLE;
                phase_d = PH_RESPONSE;
              end
              sdsp_pkg::CMD_SEND_OP, sdsp_pkg::CMD_STOP_TRAN: begin
                pend_d  = sdsp_pkg::R1_READY;
                phase_d = PH_RESPONSE;
              end
              sdsp_pkg::CMD_SET_BLKLEN: begin
                blen_d  = arg;
                pend_d  = sdsp_pkg::R1_READY;
                phase_d = PH_RESPONSE;
              end
              sdsp_pkg::CMD_READ_MULTI: begin
                rptr_d  = arg;
                pend_d  = sdsp_pkg::R1_READY;
                phase_d = PH_READ_RESPONSE;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        PH_RESPONSE: begin
          answer_o = pend_q;
          phase_d  = PH_IDLE;
        end
        PH_READ_RESPONSE: begin
          answer_o = pend_q;
          phase_d  = PH_READ;
          cnt_d    = '0;
        end
        PH_READ: begin
          if (is_cmd_byte) begin
            phase_d  = PH_COMMAND;
            frame_we = 1'b1;
            cnt_d    = 33'd1;
          end else if (cnt_q == '0) begin
            answer_o = sdsp_pkg::BYTE_TOKEN;
            cnt_d    = 33'd1;
          end else if ({1'b0, cnt_q} > len_plus2) begin
            cnt_d = '0;
          end else if (cnt_q > {1'b0, blen_q}) begin
            cnt_d = cnt_q + 33'd1;
          end else begin
            answer_o     = media_byte_i;
            took_media_o = 1'b1;
            rptr_d       = rptr_q + 32'd1;
            cnt_d        = cnt_q + 33'd1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign rd_ptr_next_o = rptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
      blen_q  <= sdsp_pkg::BLKLEN_RESET;
      pend_q  <= sdsp_pkg::BYTE_IDLE;
      rptr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
      blen_q  <= blen_d;
      pend_q  <= pend_d;
      rptr_q  <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[frame_idx] <= tx_byte_i;
    end
  end

endmodule
`default_nettype wire
